// File: hdl/maf_pkg.sv
// ----------------------------------------------------------------------------
// maf_pkg
// Shared constants, state encoding and status types of the moving average
// filter.
// ----------------------------------------------------------------------------
package maf_pkg;

    // Default parameter values
    localparam int WINDOW_MAX_DEF    = 64;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 8;

    // Window size register
    localparam int              CFG_BITS  = 7;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE
    } maf_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } maf_div_status_t;

endpackage

// File: hdl/maf_ring.sv
// ----------------------------------------------------------------------------
// maf_ring
// Sample ring memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module maf_ring #(
    parameter int DEPTH     = maf_pkg::WINDOW_MAX_DEF,
    parameter int DATA_BITS = maf_pkg::SAMPLE_BITS_DEF,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_BITS-1:0]        wr_addr,
    input  logic signed [DATA_BITS-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_BITS-1:0]        rd_addr,
    output logic signed [DATA_BITS-1:0] rd_data
);

    logic signed [DATA_BITS-1:0] mem [DEPTH];
    logic signed [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/maf_divider.sv
// ----------------------------------------------------------------------------
// maf_divider
// Bit-serial restoring divider: (numerator << SHIFT) / divisor, signed
// numerator, unsigned divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module maf_divider #(
    parameter int NUM_BITS     = 22,
    parameter int SHIFT        = maf_pkg::FRACTION_BITS_DEF,
    parameter int DIVISOR_BITS = 7,
    parameter int QUO_BITS     = NUM_BITS + SHIFT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [NUM_BITS-1:0]  numerator,
    input  logic [DIVISOR_BITS-1:0]     divisor,
    output logic signed [QUO_BITS-1:0]  quotient,
    output maf_pkg::maf_div_status_t    status
);
    import maf_pkg::*;

    localparam int CNT_BITS = $clog2(QUO_BITS);

    logic [DIVISOR_BITS-1:0] rem_reg;
    logic [QUO_BITS-1:0]     quo_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic                    neg_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic [NUM_BITS-1:0]     magnitude;
    logic [DIVISOR_BITS:0]   trial;
    logic                    fits;

    assign magnitude = numerator[NUM_BITS-1] ? -numerator : numerator;
    assign trial     = {rem_reg, quo_reg[QUO_BITS-1]};
    assign fits      = trial >= {1'b0, divisor};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_BITS'(QUO_BITS - 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= QUO_BITS'(magnitude) << SHIFT;
            neg_reg <= numerator[NUM_BITS-1];
        end else if (busy_reg) begin
            rem_reg <= fits ? DIVISOR_BITS'(trial - {1'b0, divisor})
                            : DIVISOR_BITS'(trial);
            quo_reg <= {quo_reg[QUO_BITS-2:0], fits};
        end
    end

    assign quotient    = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: hdl/moving_average_filter.sv
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar filter: keeps a ring of recent samples and their running sum, and
// once a full window has been seen returns the mean in signed fixed point.
// ----------------------------------------------------------------------------
//
//   channel  | direction | payload                               | handshake
//   ---------+-----------+---------------------------------------+--------------
//   s_       | in        | s_sample_value, s_starts_sequence     | s_valid/ready
//   m_       | out       | m_window_mean                         | m_valid/ready
//   cfg_     | in        | cfg_window_size                       | cfg_valid/ready
//
// A request without a result reads the ring slot of the oldest sample, then
// updates the sum and writes the sample back. A request with a result also
// starts the bit-serial divider and waits in ST_DIVIDE for the quotient.
// Synchronous active-low reset clears fill count, sum, write slot and sets
// the window size to 3; the ring itself is not cleared.
// A stalled result sits in the output register while the next request is
// taken; only a second finished result waits for the first to drain.
// ----------------------------------------------------------------------------
module moving_average_filter #(
    parameter int WINDOW_MAX    = maf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS   = maf_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = maf_pkg::FRACTION_BITS_DEF,
    parameter int MEAN_BITS     = SAMPLE_BITS + FRACTION_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // sample requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_value,
    input  logic                          s_starts_sequence,
    // results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [MEAN_BITS-1:0]   m_window_mean,
    // window size register
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [maf_pkg::CFG_BITS-1:0]  cfg_window_size
);
    import maf_pkg::*;

    localparam int AW       = $clog2(WINDOW_MAX);
    localparam int KA       = AW + 1;
    localparam int KMIN     = $clog2(WINDOW_MAX + 1);
    localparam int KW       = (KMIN > CFG_BITS) ? KMIN : CFG_BITS;
    localparam int SUM_BITS = SAMPLE_BITS + AW;
    localparam int QUO_BITS = SUM_BITS + FRACTION_BITS;

    maf_state_t                   state_reg, state_next;
    logic [CFG_BITS-1:0]          cfg_reg, cfg_next;
    logic [KW-1:0]                fill_reg, fill_next;
    logic signed [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [AW-1:0]                wp_reg, wp_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                         m_valid_reg, m_valid_next;
    logic signed [MEAN_BITS-1:0]  mean_reg, mean_next;

    logic [KW-1:0]                cfg_ext;
    logic [KW-1:0]                k_eff;
    logic [KA-1:0]                k_addr;
    logic [KA-1:0]                oldest_diff;
    logic [AW-1:0]                oldest_addr;
    logic [AW-1:0]                wp_inc;
    logic [KW-1:0]                fill_upd;
    logic signed [SUM_BITS-1:0]   sum_upd;
    logic signed [SUM_BITS-1:0]   drop_val;

    logic                         rd_en;
    logic                         wr_en;
    logic signed [SAMPLE_BITS-1:0] rd_data;
    logic                         div_start;
    logic signed [QUO_BITS-1:0]   div_quotient;
    maf_div_status_t              div_status;

    // Effective window size: zero acts as one, clamp at the ring depth
    assign cfg_ext = KW'(cfg_reg);
    always_comb begin
        if (cfg_ext == '0) begin
            k_eff = KW'(1);
        end else if (cfg_ext > KW'(WINDOW_MAX)) begin
            k_eff = KW'(WINDOW_MAX);
        end else begin
            k_eff = cfg_ext;
        end
    end

    // Slot of the sample that drops out of the window
    assign k_addr      = KA'(k_eff);
    assign oldest_diff = {1'b0, wp_reg} - k_addr;
    assign oldest_addr = ({1'b0, wp_reg} >= k_addr) ? AW'(oldest_diff)
                                                    : AW'(oldest_diff + KA'(WINDOW_MAX));

    assign wp_inc   = (wp_reg == AW'(WINDOW_MAX - 1)) ? '0 : wp_reg + 1'b1;
    assign fill_upd = (fill_reg < k_eff) ? fill_reg + 1'b1 : fill_reg;
    assign drop_val = (fill_reg >= k_eff) ? SUM_BITS'(rd_data) : '0;
    assign sum_upd  = sum_reg - drop_val + SUM_BITS'(sample_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cfg_reg     <= CFG_RESET;
            fill_reg    <= '0;
            sum_reg     <= '0;
            wp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cfg_reg     <= cfg_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            wp_reg      <= wp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        mean_reg   <= mean_next;
    end

    always_comb begin
        state_next   = state_reg;
        cfg_next     = cfg_reg;
        fill_next    = fill_reg;
        sum_next     = sum_reg;
        wp_next      = wp_reg;
        sample_next  = sample_reg;
        m_valid_next = m_valid_reg;
        mean_next    = mean_reg;
        s_ready      = 1'b0;
        cfg_ready    = 1'b0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        div_start    = 1'b0;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_ready   = !cfg_valid;
                if (cfg_valid) begin
                    // new window size restarts the fill; keep the write slot
                    cfg_next  = cfg_window_size;
                    fill_next = '0;
                    sum_next  = '0;
                end else if (s_valid) begin
                    sample_next = s_sample_value;
                    rd_en       = 1'b1;
                    if (s_starts_sequence) begin
                        fill_next = '0;
                        sum_next  = '0;
                    end
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // ring data for the oldest slot is here; write the new sample
                wr_en     = 1'b1;
                sum_next  = sum_upd;
                wp_next   = wp_inc;
                fill_next = fill_upd;
                if (fill_upd >= k_eff) begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                // hold the quotient until the output register is free
                if (div_status.done && (!m_valid_reg || m_ready)) begin
                    m_valid_next = 1'b1;
                    mean_next    = MEAN_BITS'(div_quotient);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    maf_ring #(
        .DEPTH     (WINDOW_MAX),
        .DATA_BITS (SAMPLE_BITS),
        .ADDR_BITS (AW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_en   (rd_en),
        .rd_addr (oldest_addr),
        .rd_data (rd_data)
    );

    maf_divider #(
        .NUM_BITS     (SUM_BITS),
        .SHIFT        (FRACTION_BITS),
        .DIVISOR_BITS (KW),
        .QUO_BITS     (QUO_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .numerator (sum_upd),
        .divisor   (k_eff),
        .quotient  (div_quotient),
        .status    (div_status)
    );

    assign m_valid       = m_valid_reg;
    assign m_window_mean = mean_reg;

endmodule

// File: hdl/maf_checker.sv
// ----------------------------------------------------------------------------
// maf_checker
// Port-level checks of the moving average filter, bound to the top level.
// ----------------------------------------------------------------------------
module maf_checker #(
    parameter int MEAN_BITS = maf_pkg::SAMPLE_BITS_DEF + maf_pkg::FRACTION_BITS_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [MEAN_BITS-1:0] m_window_mean,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);

    // a stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_window_mean))
        else $error("stalled result changed");

    // no result survives reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one request at a time: the input is closed in the cycle after a request is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one in flight");

    // a register write and a sample request never complete together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cfg_valid && cfg_ready && s_valid && s_ready))
        else $error("register write and request taken in the same cycle");

endmodule

bind moving_average_filter maf_checker #(
    .MEAN_BITS (MEAN_BITS)
) u_maf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_window_mean (m_window_mean),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);
